[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication checked out of reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfbm_pkg.sv]
package sfbm_pkg;

    localparam int NUM_SLOTS  = 512;
    localparam int MAX_HOPS   = 8;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = 10;
    localparam int BUSY_W     = 8;
    localparam int HOPS_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int HOP_CAP    = (MAX_HOPS < BUSY_W) ? MAX_HOPS : BUSY_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_CALL_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_COUNT = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0]  call_size;
        logic [HOPS_W-1:0] hop_count;
    } t_cfg;

    typedef struct packed {
        logic              fit_found;
        logic [SLOT_W-1:0] fit_start;
        logic [CNT_W-1:0]  placement_count;
        logic [CNT_W-1:0]  simultaneous_count;
        logic [CNT_W-1:0]  largest_block;
        logic [CNT_W-1:0]  free_total;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

[hw/rtl/spectrum_free_block_metrics.sv]
// A last_slot beat passes the input register, then the result register on o_out_*.
// Throughput: one slot beat per cycle; the output register lets new beats in while
// a result waits to be taken; a beat carrying last_slot stalls until it is taken.
// Reset: synchronous, active low; call_size and hop_count return to 1 and all
// scan counters clear.
`include "assert_macros.svh"

module spectrum_free_block_metrics
    import sfbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BUSY_W-1:0]     i_hop_busy,
    input  logic                  i_last_slot,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_fit_found,
    output logic [SLOT_W-1:0]     o_fit_start,
    output logic [CNT_W-1:0]      o_placement_count,
    output logic [CNT_W-1:0]      o_simultaneous_count,
    output logic [CNT_W-1:0]      o_largest_block,
    output logic [CNT_W-1:0]      o_free_total
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BUSY_W-1:0] r_busy;
    logic              r_last;
    logic              r_out_valid;
    t_result           r_result;
    t_result           scan_result;
    logic              out_free;
    logic              step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.call_size <= CNT_W'(1);
            r_cfg.hop_count <= HOPS_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CALL_SIZE: r_cfg.call_size <= i_cfg_data[CNT_W-1:0];
                REG_HOP_COUNT: r_cfg.hop_count <= i_cfg_data[HOPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_last || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_busy <= i_hop_busy;
            r_last <= i_last_slot;
        end
    end

    sfbm_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_busy   (r_busy),
        .i_last   (r_last),
        .i_cfg    (r_cfg),
        .o_result (scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_last) begin
            r_result <= scan_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_fit_found          = r_result.fit_found;
    assign o_fit_start          = r_result.fit_start;
    assign o_placement_count    = r_result.placement_count;
    assign o_simultaneous_count = r_result.simultaneous_count;
    assign o_largest_block      = r_result.largest_block;
    assign o_free_total         = r_result.free_total;

    `ASSERT_IMPLY(a_no_fit_zero_start, o_out_valid && !o_fit_found, o_fit_start == '0, "start set without fit")
    `ASSERT_IMPLY(a_largest_within_free, o_out_valid, o_largest_block <= o_free_total, "largest block above free total")
    `ASSERT_IMPLY(a_fit_counts, o_out_valid && o_fit_found, (o_placement_count != '0) && (o_simultaneous_count != '0), "fit without counts")

endmodule

[hw/rtl/sfbm_scan.sv]
`include "assert_macros.svh"

module sfbm_scan
    import sfbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BUSY_W-1:0] i_busy,
    input  logic              i_last,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [SLOT_W-1:0] r_pos,     n_pos;
    logic [CNT_W-1:0]  r_run,     n_run;
    logic [CNT_W-1:0]  r_wrap,    n_wrap;
    logic [CNT_W-1:0]  r_place,   n_place;
    logic [CNT_W-1:0]  r_sim,     n_sim;
    logic [CNT_W-1:0]  r_longest, n_longest;
    logic [CNT_W-1:0]  r_free,    n_free;
    logic              r_found,   n_found;
    logic [SLOT_W-1:0] r_start,   n_start;

    logic [CNT_W-1:0]  size;
    logic [CNT_W-1:0]  size_m1;
    logic [HOPS_W-1:0] hops;
    logic [BUSY_W-1:0] mask;
    logic              slot_free;
    logic [CNT_W-1:0]  wrap_inc;
    logic [SLOT_W-1:0] back;
    logic [SLOT_W:0]   start_sum;
    logic [SLOT_W-1:0] start_pos;

    always_comb begin
        size    = (i_cfg.call_size == '0) ? CNT_W'(1) : i_cfg.call_size;
        size_m1 = size - 1'b1;
        hops    = (i_cfg.hop_count > HOPS_W'(HOP_CAP)) ? HOPS_W'(HOP_CAP) : i_cfg.hop_count;
        for (int h = 0; h < BUSY_W; h++) begin
            mask[h] = (HOPS_W'(h) < hops);
        end
        slot_free = ((i_busy & mask) == '0);

        // start = (pos - (size - 1)) modulo the spectrum width
        back      = SLOT_W'(size_m1 % NUM_SLOTS);
        start_sum = {1'b0, r_pos} + (SLOT_W+1)'(NUM_SLOTS) - {1'b0, back};
        start_pos = (start_sum >= (SLOT_W+1)'(NUM_SLOTS))
                    ? SLOT_W'(start_sum - (SLOT_W+1)'(NUM_SLOTS))
                    : SLOT_W'(start_sum);
    end

    always_comb begin
        n_run     = r_run;
        n_wrap    = r_wrap;
        n_place   = r_place;
        n_sim     = r_sim;
        n_longest = r_longest;
        n_free    = r_free;
        n_found   = r_found;
        n_start   = r_start;
        wrap_inc  = sat_inc(r_wrap);
        n_pos     = (r_pos == SLOT_W'(NUM_SLOTS - 1)) ? '0 : r_pos + 1'b1;

        if (slot_free) begin
            n_run     = sat_inc(r_run);
            n_free    = sat_inc(r_free);
            n_longest = (n_run > r_longest) ? n_run : r_longest;
            if (n_run >= size) begin
                n_place = sat_inc(r_place);
            end
            if (wrap_inc >= size) begin
                n_sim  = sat_inc(r_sim);
                n_wrap = '0;
            end else begin
                n_wrap = wrap_inc;
            end
            if (!r_found && (n_run == size)) begin
                n_found = 1'b1;
                n_start = start_pos;
            end
        end else begin
            n_run  = '0;
            n_wrap = '0;
        end

        o_result.fit_found          = n_found;
        o_result.fit_start          = n_found ? n_start : '0;
        o_result.placement_count    = n_place;
        o_result.simultaneous_count = n_sim;
        o_result.largest_block      = n_longest;
        o_result.free_total         = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos     <= '0;
            r_run     <= '0;
            r_wrap    <= '0;
            r_place   <= '0;
            r_sim     <= '0;
            r_longest <= '0;
            r_free    <= '0;
            r_found   <= 1'b0;
            r_start   <= '0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_run     <= n_run;
            r_wrap    <= n_wrap;
            r_place   <= n_place;
            r_sim     <= n_sim;
            r_longest <= n_longest;
            r_free    <= n_free;
            r_found   <= n_found;
            r_start   <= n_start;
        end
    end

    `ASSERT_ALWAYS(a_longest_covers_run, r_longest >= r_run, "longest run below current run")
    `ASSERT_ALWAYS(a_wrap_within_run, r_wrap <= r_run, "wrap counter exceeds current run")
    `ASSERT_ALWAYS(a_free_covers_longest, r_free >= r_longest, "free total below longest run")

endmodule
